[design/debounced_button_timed_light_macros.svh]
// Assertion macros used by the staircase light timer top-level design file.
// DBTL_ASSERT expects clk and arst_n in scope at the point of use, DBTL_ASSERT_ALWAYS only clk.
`ifndef DEBOUNCED_BUTTON_TIMED_LIGHT_MACROS_SVH
`define DEBOUNCED_BUTTON_TIMED_LIGHT_MACROS_SVH

// Check a property on every clock edge outside reset
`define DBTL_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define DBTL_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/dbtl_pkg.sv]
// Shared types and constants for the debounced button timed light.
// No dependencies.
package dbtl_pkg;

	// threshold register width
	localparam int REG_W = 26;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 2'd2;

	// register reset values
	localparam logic [REG_W-1:0] DEBOUNCE_RST   = 26'd50000;
	localparam logic [REG_W-1:0] LONG_PRESS_RST = 26'd2000000;
	localparam logic [REG_W-1:0] TIMEOUT_RST    = 26'd30000000;

	// event codes
	localparam int EV_W = 3;
	localparam logic [EV_W-1:0] EV_NONE    = 3'd0;
	localparam logic [EV_W-1:0] EV_ON      = 3'd1;
	localparam logic [EV_W-1:0] EV_RESTART = 3'd2;
	localparam logic [EV_W-1:0] EV_LONG    = 3'd3;
	localparam logic [EV_W-1:0] EV_TIMEOUT = 3'd4;

	// debouncer outcome for the current item
	typedef struct packed {
		logic level;        // debounced level after this item, 0 pressed
		logic press_acc;    // press accepted on this item
		logic release_acc;  // release accepted on this item
	} deb_t;

endpackage

[design/debounced_button_timed_light.sv]
// An accepted item passes through the input stage and then the result stage.
// Throughput: one item per cycle; both stages advance together whenever the result
// register is empty or being taken, so the stall path is the output ready alone.
// Reset: counters and light clear, button level reads released, stable count saturated,
// thresholds return to 50000, 2000000 and 30000000 ticks; no item is held after reset.
`include "debounced_button_timed_light_macros.svh"

module debounced_button_timed_light #(
	parameter int COUNT_BITS = 26
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           raw_button,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           light_on,
	output logic                           button_level,
	output logic [dbtl_pkg::EV_W-1:0]      event_code,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [dbtl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dbtl_pkg::REG_W-1:0]     cfg_data
);
	import dbtl_pkg::*;

	logic [REG_W-1:0] debounce_q;
	logic [REG_W-1:0] long_press_q;
	logic [REG_W-1:0] timeout_q;

	logic             valid_s1;
	logic             raw_s1;
	logic             out_valid_q;
	logic             light_on_q;
	logic             level_q;
	logic [EV_W-1:0]  event_q;

	logic             adv;
	deb_t             deb;
	logic             light_next;
	logic [EV_W-1:0]  ev_next;

	// configuration writes land at once
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= DEBOUNCE_RST;
			long_press_q <= LONG_PRESS_RST;
			timeout_q    <= TIMEOUT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_DEBOUNCE:   debounce_q   <= cfg_data;
				CFG_LONG_PRESS: long_press_q <= cfg_data;
				CFG_TIMEOUT:    timeout_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// move the staged item into the result register when it has room
	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			raw_s1 <= raw_button;
		end
	end

	dbtl_debounce #(
		.COUNT_BITS(COUNT_BITS)
	) u_debounce (
		.clk            (clk),
		.arst_n         (arst_n),
		.adv            (adv),
		.raw            (raw_s1),
		.debounce_ticks (debounce_q),
		.deb            (deb)
	);

	dbtl_light #(
		.COUNT_BITS(COUNT_BITS)
	) u_light (
		.clk              (clk),
		.arst_n           (arst_n),
		.adv              (adv),
		.deb              (deb),
		.long_press_ticks (long_press_q),
		.timeout_ticks    (timeout_q),
		.light_next       (light_next),
		.ev_next          (ev_next)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			light_on_q <= light_next;
			level_q    <= deb.level;
			event_q    <= ev_next;
		end
	end

	assign out_valid    = out_valid_q;
	assign light_on     = light_on_q;
	assign button_level = level_q;
	assign event_code   = event_q;

	// a result never carries an unused event code
	`DBTL_ASSERT(a_ev_range, out_valid_q |-> (event_q <= EV_TIMEOUT), "event code out of range")
	// switch-on and restart leave the light lit after a release
	`DBTL_ASSERT(a_on_lit, out_valid_q && (event_q == EV_ON || event_q == EV_RESTART) |-> light_on_q && level_q, "on event without lit light")
	// both off events leave the light dark; long press only while pressed
	`DBTL_ASSERT(a_off_dark, out_valid_q && (event_q == EV_LONG || event_q == EV_TIMEOUT) |-> !light_on_q, "off event with lit light")
	`DBTL_ASSERT(a_long_pressed, out_valid_q && (event_q == EV_LONG) |-> !level_q, "long press while released")
	// a staged item that cannot move stays staged
	`DBTL_ASSERT_ALWAYS(a_stage_hold, arst_n && valid_s1 && !adv |=> !arst_n || valid_s1, "staged item lost")

endmodule

[design/dbtl_debounce.sv]
// Debouncer for the raw active-low button sample.
// Depends on dbtl_pkg.
module dbtl_debounce #(
	parameter int COUNT_BITS = 26
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  logic                      raw,
	input  logic [dbtl_pkg::REG_W-1:0] debounce_ticks,
	output dbtl_pkg::deb_t            deb
);
	import dbtl_pkg::*;

	localparam int CmpW = (COUNT_BITS > REG_W) ? COUNT_BITS : REG_W;

	logic                  prev_raw_q;
	logic                  level_q;
	logic [COUNT_BITS-1:0] stable_q;
	logic [COUNT_BITS-1:0] stable_next;
	logic                  take;

	// restart the stable count on a raw change, else saturate upward
	always_comb begin
		if (raw != prev_raw_q) begin
			stable_next = '0;
		end else if (stable_q == {COUNT_BITS{1'b1}}) begin
			stable_next = stable_q;
		end else begin
			stable_next = stable_q + 1'b1;
		end
	end

	// accept a new level once stable for more than the debounce count
	assign take = (CmpW'(stable_next) > CmpW'(debounce_ticks)) && (raw != level_q);

	assign deb.level       = take ? raw : level_q;
	assign deb.press_acc   = take && !raw;
	assign deb.release_acc = take && raw;

	// advance the debounce state once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_raw_q <= 1'b1;
			level_q    <= 1'b1;
			stable_q   <= {COUNT_BITS{1'b1}};
		end else if (adv) begin
			prev_raw_q <= raw;
			level_q    <= deb.level;
			stable_q   <= stable_next;
		end
	end

endmodule

[design/dbtl_light.sv]
// Light controller: switch-on, restart, long-press off and timeout off.
// Depends on dbtl_pkg.
module dbtl_light #(
	parameter int COUNT_BITS = 26
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  dbtl_pkg::deb_t             deb,
	input  logic [dbtl_pkg::REG_W-1:0] long_press_ticks,
	input  logic [dbtl_pkg::REG_W-1:0] timeout_ticks,
	output logic                       light_next,
	output logic [dbtl_pkg::EV_W-1:0]  ev_next
);
	import dbtl_pkg::*;

	localparam int CmpW = (COUNT_BITS > REG_W) ? COUNT_BITS : REG_W;

	logic                  light_q;
	logic                  lpd_q;
	logic [COUNT_BITS-1:0] held_q;
	logic [COUNT_BITS-1:0] lit_q;

	logic                  lpd_next;
	logic [COUNT_BITS-1:0] held_next;
	logic [COUNT_BITS-1:0] lit_next;
	logic                  restarted;

	// work through debounce, long press and timeout in that order
	always_comb begin
		ev_next    = EV_NONE;
		light_next = light_q;
		lpd_next   = lpd_q;
		held_next  = held_q;
		lit_next   = lit_q;
		restarted  = 1'b0;

		if (deb.press_acc) begin
			held_next = '0;
			lpd_next  = 1'b0;
		end
		if (deb.release_acc && !lpd_q) begin
			ev_next    = light_q ? EV_RESTART : EV_ON;
			light_next = 1'b1;
			lit_next   = '0;
			restarted  = 1'b1;
		end

		// saturating hold and lit counters
		if (!deb.level && !deb.press_acc && (held_q != {COUNT_BITS{1'b1}})) begin
			held_next = held_q + 1'b1;
		end
		if (light_next && !restarted && (lit_q != {COUNT_BITS{1'b1}})) begin
			lit_next = lit_q + 1'b1;
		end

		if (!deb.level && !lpd_next && (CmpW'(held_next) >= CmpW'(long_press_ticks))) begin
			light_next = 1'b0;
			lpd_next   = 1'b1;
			ev_next    = EV_LONG;
		end
		if (light_next && (CmpW'(lit_next) >= CmpW'(timeout_ticks))) begin
			light_next = 1'b0;
			ev_next    = EV_TIMEOUT;
		end
	end

	// advance the light state once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_q <= 1'b0;
			lpd_q   <= 1'b0;
			held_q  <= '0;
			lit_q   <= '0;
		end else if (adv) begin
			light_q <= light_next;
			lpd_q   <= lpd_next;
			held_q  <= held_next;
			lit_q   <= lit_next;
		end
	end

endmodule
